FILE: rtl/htfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared widths, CRC-8 constants and the byte CRC update for the
// humidity and temperature frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int RAW_W  = 16;
  localparam int TEMP_W = 15;
  localparam int RH_W   = 7;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // frame byte positions
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // CRC-8, MSB first, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/htfd_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_convert
// Scales raw temperature and humidity counts to centidegrees and percent,
// dividing by 65535 through the 2^16 = 65535 + 1 fold.
// ----------------------------------------------------------------------------
module htfd_convert
  import htfd_pkg::*;
(
  input  wire logic        [RAW_W-1:0]  temp_raw,
  input  wire logic        [RAW_W-1:0]  humid_raw,
  output logic signed      [TEMP_W-1:0] temp_centi,
  output logic             [RH_W-1:0]   rh_percent
);

  localparam logic [16:0] FULL_SCALE = 17'd65535;
  localparam logic [14:0] T_OFFSET   = 15'd4500;

  logic [30:0] t_prod;
  logic [16:0] t_sum;
  logic        t_ge;
  logic [14:0] t_quot;
  logic        t_rem_zero;
  logic        t_neg;
  logic signed [15:0] t_res;

  logic [22:0] h_prod;
  logic [16:0] h_sum;
  logic        h_ge;

  // p = a*65536 + b = a*65535 + (a + b), and a + b stays below 2*65535
  always_comb begin
    t_prod     = 31'(temp_raw) * 31'd17500;
    t_sum      = {2'b00, t_prod[30:16]} + {1'b0, t_prod[15:0]};
    t_ge       = (t_sum >= FULL_SCALE);
    t_quot     = t_prod[30:16] + {14'd0, t_ge};
    t_rem_zero = (t_sum == 17'd0) || (t_sum == FULL_SCALE);
    t_neg      = (t_quot < T_OFFSET);
    // truncate toward zero: round the floor up when negative and inexact
    t_res      = $signed({1'b0, t_quot}) - $signed({1'b0, T_OFFSET})
                 + $signed({15'd0, t_neg && !t_rem_zero});
    temp_centi = t_res[TEMP_W-1:0];

    h_prod     = 23'(humid_raw) * 23'd100;
    h_sum      = {10'd0, h_prod[22:16]} + {1'b0, h_prod[15:0]};
    h_ge       = (h_sum >= FULL_SCALE);
    rh_percent = h_prod[22:16] + {6'd0, h_ge};
  end

endmodule
`default_nettype wire

FILE: rtl/humidity_temp_frame_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// A byte is registered in the input register on acceptance; a frame's result
// is loaded into the output register when its last byte advances from there.
// Throughput: one byte per cycle; only the last byte of a frame waits for a
// free output register. CRC and scaling fit in one pass between registers.
// Reset: synchronous, active high; position zero, CRC 0xFF, raws cleared.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] start_of_frame
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [14:0] temp_centi, [21:15] rh_percent, zero fill
  output logic             m_tuser    // [0] status
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_sof;

  logic [2:0]       byte_position;
  logic [2:0]       byte_position_next;
  logic [7:0]       running_crc;
  logic [7:0]       running_crc_next;
  logic [RAW_W-1:0] temp_raw;
  logic [RAW_W-1:0] temp_raw_next;
  logic [RAW_W-1:0] humid_raw;
  logic [RAW_W-1:0] humid_raw_next;
  logic             temp_crc_good;
  logic             temp_crc_good_next;

  logic [2:0]       pos;
  logic             is_last;
  logic             out_free;
  logic             advance;
  logic             frame_ok;

  logic signed [TEMP_W-1:0] conv_temp;
  logic        [RH_W-1:0]   conv_rh;

  htfd_convert u_convert (
    .temp_raw   (temp_raw),
    .humid_raw  (humid_raw),
    .temp_centi (conv_temp),
    .rh_percent (conv_rh)
  );

  assign out_free = !m_tvalid || m_tready;
  assign is_last  = (pos == POS_H_CRC);
  assign advance  = in_valid && (!is_last || out_free);
  assign s_tready = !in_valid || advance;
  assign frame_ok = temp_crc_good && (running_crc == in_byte);

  always_comb begin
    pos = in_sof ? POS_T_HI : byte_position;
    if (pos > POS_H_CRC) begin
      pos = POS_T_HI;
    end

    byte_position_next = pos + 3'd1;
    running_crc_next   = running_crc;
    temp_raw_next      = temp_raw;
    humid_raw_next     = humid_raw;
    temp_crc_good_next = temp_crc_good;

    case (pos)
      POS_T_HI: begin
        temp_raw_next    = {in_byte, 8'h00};
        running_crc_next = crc8_byte(CRC_INIT, in_byte);
      end
      POS_T_LO: begin
        temp_raw_next    = {temp_raw[15:8], in_byte};
        running_crc_next = crc8_byte(running_crc, in_byte);
      end
      POS_T_CRC: begin
        temp_crc_good_next = (running_crc == in_byte);
        running_crc_next   = CRC_INIT;
      end
      POS_H_HI: begin
        humid_raw_next   = {in_byte, 8'h00};
        running_crc_next = crc8_byte(CRC_INIT, in_byte);
      end
      POS_H_LO: begin
        humid_raw_next   = {humid_raw[15:8], in_byte};
        running_crc_next = crc8_byte(running_crc, in_byte);
      end
      default: begin
        byte_position_next = POS_T_HI;
        running_crc_next   = CRC_INIT;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_sof  <= s_tuser;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_T_HI;
      running_crc   <= CRC_INIT;
      temp_raw      <= '0;
      humid_raw     <= '0;
      temp_crc_good <= 1'b0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      temp_raw      <= temp_raw_next;
      humid_raw     <= humid_raw_next;
      temp_crc_good <= temp_crc_good_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && is_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && is_last) begin
      if (frame_ok) begin
        m_tdata <= {2'b00, conv_rh, conv_temp};
        m_tuser <= STATUS_OK;
      end else begin
        m_tdata <= '0;
        m_tuser <= STATUS_CRC_ERR;
      end
    end
  end

endmodule
`default_nettype wire
